[hw/rtl/pbrd_pkg.sv]
package pbrd_pkg;

	localparam int MAX_ROW_BYTES = 1024;
	localparam int MAX_PLANES    = 8;
	localparam int MAX_ROWS      = 1024;

	localparam int ROWB_W  = 11;
	localparam int PLANE_W = 3;
	localparam int PCNT_W  = 4;
	localparam int ROW_W   = 10;
	localparam int RCNT_W  = 11;
	localparam int COL_W   = 10;
	localparam int CFG_W   = 11;
	localparam int CIDX_W  = 2;

	localparam logic [CIDX_W-1:0] REG_MODE      = 2'd0;
	localparam logic [CIDX_W-1:0] REG_ROW_BYTES = 2'd1;
	localparam logic [CIDX_W-1:0] REG_PLANES    = 2'd2;
	localparam logic [CIDX_W-1:0] REG_ROWS      = 2'd3;

	localparam logic              RST_MODE      = 1'b1;
	localparam logic [ROWB_W-1:0] RST_ROW_BYTES = 11'd40;
	localparam logic [PCNT_W-1:0] RST_PLANES    = 4'd5;
	localparam logic [RCNT_W-1:0] RST_ROWS      = 11'd256;

	localparam logic [7:0] NOOP_HEADER = 8'h80;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_LITERAL,
		PH_REPEAT
	} phase_t;

	typedef struct packed {
		logic              mode;
		logic [ROWB_W-1:0] row_bytes;
		logic [PCNT_W-1:0] planes;
		logic [RCNT_W-1:0] rows;
	} cfg_t;

	typedef struct packed {
		logic [7:0]         value;
		logic [7:0]         repeat_res;
		logic [PLANE_W-1:0] plane_index;
		logic [ROW_W-1:0]   row_index;
		logic [COL_W-1:0]   column;
		logic               row_end;
		logic               image_end;
		logic               overrun_error;
	} res_t;

	function automatic logic [ROWB_W-1:0] clamp_rowb(input logic [ROWB_W-1:0] v);
		logic [ROWB_W-1:0] r;
		r = v;
		if (v == '0)
			r = ROWB_W'(1);
		else if (v > ROWB_W'(MAX_ROW_BYTES))
			r = ROWB_W'(MAX_ROW_BYTES);
		return r;
	endfunction

	function automatic logic [PCNT_W-1:0] clamp_planes(input logic [PCNT_W-1:0] v);
		logic [PCNT_W-1:0] r;
		r = v;
		if (v == '0)
			r = PCNT_W'(1);
		else if (v > PCNT_W'(MAX_PLANES))
			r = PCNT_W'(MAX_PLANES);
		return r;
	endfunction

	function automatic logic [RCNT_W-1:0] clamp_rows(input logic [RCNT_W-1:0] v);
		logic [RCNT_W-1:0] r;
		r = v;
		if (v == '0)
			r = RCNT_W'(1);
		else if (v > RCNT_W'(MAX_ROWS))
			r = RCNT_W'(MAX_ROWS);
		return r;
	endfunction

endpackage

[hw/rtl/pbrd_cfg.sv]
module pbrd_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [pbrd_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [pbrd_pkg::CFG_W-1:0]   cfg_data,
	output pbrd_pkg::cfg_t               cfg,
	output logic                         restart
);
	import pbrd_pkg::*;

	logic              mode_q;
	logic [ROWB_W-1:0] row_bytes_q;
	logic [PCNT_W-1:0] planes_q;
	logic [RCNT_W-1:0] rows_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= RST_MODE;
			row_bytes_q <= RST_ROW_BYTES;
			planes_q    <= RST_PLANES;
			rows_q      <= RST_ROWS;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:      mode_q      <= cfg_data[0];
				REG_ROW_BYTES: row_bytes_q <= cfg_data[ROWB_W-1:0];
				REG_PLANES:    planes_q    <= cfg_data[PCNT_W-1:0];
				REG_ROWS:      rows_q      <= cfg_data[RCNT_W-1:0];
				default: ;
			endcase
		end
	end

	// decode state restarts after any write; it sees the new value next cycle
	always_comb begin
		restart = 1'b0;
		case (cfg_index)
			REG_MODE, REG_ROW_BYTES, REG_PLANES, REG_ROWS: restart = cfg_we;
			default: restart = 1'b0;
		endcase
	end

	assign cfg.mode      = mode_q;
	assign cfg.row_bytes = clamp_rowb(row_bytes_q);
	assign cfg.planes    = clamp_planes(planes_q);
	assign cfg.rows      = clamp_rows(rows_q);

endmodule

[hw/rtl/pbrd_step.sv]
module pbrd_step (
	input  logic           clk,
	input  logic           arst_n,
	input  pbrd_pkg::cfg_t cfg,
	input  logic           restart,
	input  logic           step_en,
	input  logic [7:0]     byte_s1,
	output pbrd_pkg::res_t res,
	output logic           res_vld
);
	import pbrd_pkg::*;

	phase_t             phase_q, phase_n;
	logic [7:0]         lit_q, lit_n;
	logic [7:0]         pend_q, pend_n;
	logic [ROWB_W-1:0]  left_q, left_n;
	logic [PLANE_W-1:0] plane_q, plane_n;
	logic [ROW_W-1:0]   row_q, row_n;
	logic               fin_q, fin_n;
	logic               err_q, err_n;
	logic               pend_seen_q;

	logic               emitting, ovr, row_end, image_end;
	logic [7:0]         count, hc;
	logic [ROWB_W-1:0]  left_sub, col_full;
	logic [PCNT_W-1:0]  plane_inc;
	logic [RCNT_W-1:0]  row_inc;

	always_comb begin
		phase_n   = phase_q;
		lit_n     = lit_q;
		pend_n    = pend_q;
		left_n    = left_q;
		plane_n   = plane_q;
		row_n     = row_q;
		fin_n     = fin_q;
		err_n     = err_q;
		emitting  = 1'b0;
		ovr       = 1'b0;
		count     = 8'd1;
		hc        = 8'd1;
		row_end   = 1'b0;
		image_end = 1'b0;
		left_sub  = left_q;
		plane_inc = {1'b0, plane_q} + PCNT_W'(1);
		row_inc   = {1'b0, row_q} + RCNT_W'(1);

		if (!fin_q && !err_q) begin
			if (!cfg.mode) begin
				emitting = 1'b1;
			end else begin
				case (phase_q)
					PH_LITERAL: begin
						if (lit_q != 8'd0)
							lit_n = lit_q - 8'd1;
						if (lit_n == 8'd0)
							phase_n = PH_HEADER;
						emitting = 1'b1;
					end
					PH_REPEAT: begin
						count    = (pend_q == 8'd0) ? 8'd1 : pend_q;
						pend_n   = 8'd0;
						phase_n  = PH_HEADER;
						emitting = 1'b1;
					end
					PH_HEADER: begin
						if (!byte_s1[7]) begin
							hc = {1'b0, byte_s1[6:0]} + 8'd1;
							if ({3'b0, hc} > left_q) begin
								ovr   = 1'b1;
								err_n = 1'b1;
							end else begin
								lit_n   = hc;
								phase_n = PH_LITERAL;
							end
						end else if (byte_s1 != NOOP_HEADER) begin
							hc = 8'd1 - byte_s1;
							if ({3'b0, hc} > left_q) begin
								ovr   = 1'b1;
								err_n = 1'b1;
							end else begin
								pend_n  = hc;
								phase_n = PH_REPEAT;
							end
						end
					end
					default: phase_n = PH_HEADER;
				endcase
			end
		end

		if (emitting) begin
			left_sub = ({3'b0, count} >= left_q) ? '0 : left_q - {3'b0, count};
			left_n   = left_sub;
			if (left_sub == '0) begin
				row_end = 1'b1;
				phase_n = PH_HEADER;
				lit_n   = 8'd0;
				pend_n  = 8'd0;
				left_n  = cfg.row_bytes;
				plane_n = plane_inc[PLANE_W-1:0];
				if (plane_inc >= cfg.planes) begin
					plane_n = '0;
					row_n   = row_inc[ROW_W-1:0];
					if (row_inc >= cfg.rows) begin
						row_n     = '0;
						fin_n     = 1'b1;
						image_end = 1'b1;
					end
				end
			end
		end
	end

	assign col_full = cfg.row_bytes - left_q;

	always_comb begin
		res_vld           = emitting || ovr;
		res.value         = ovr ? 8'd0 : byte_s1;
		res.repeat_res    = ovr ? 8'd0 : count;
		res.plane_index   = plane_q;
		res.row_index     = row_q;
		res.column        = col_full[COL_W-1:0];
		res.row_end       = row_end;
		res.image_end     = image_end;
		res.overrun_error = ovr;
	end

	// left_q is loaded from the clamped row length on the first cycle out of reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			lit_q       <= '0;
			pend_q      <= '0;
			left_q      <= RST_ROW_BYTES;
			plane_q     <= '0;
			row_q       <= '0;
			fin_q       <= 1'b0;
			err_q       <= 1'b0;
			pend_seen_q <= 1'b0;
		end else if (restart) begin
			phase_q     <= PH_HEADER;
			lit_q       <= '0;
			pend_q      <= '0;
			left_q      <= '0;
			plane_q     <= '0;
			row_q       <= '0;
			fin_q       <= 1'b0;
			err_q       <= 1'b0;
			pend_seen_q <= 1'b0;
		end else begin
			if (!pend_seen_q) begin
				left_q      <= cfg.row_bytes;
				pend_seen_q <= 1'b1;
			end
			if (step_en && pend_seen_q) begin
				phase_q <= phase_n;
				lit_q   <= lit_n;
				pend_q  <= pend_n;
				left_q  <= left_n;
				plane_q <= plane_n;
				row_q   <= row_n;
				fin_q   <= fin_n;
				err_q   <= err_n;
			end
		end
	end

endmodule

[hw/rtl/planar_byterun1_decoder.sv]
// Decodes an interleaved planar image body, one byte per beat, in pass-through
// or ByteRun1 mode. Steady rate is one byte per clock while out_ready is high:
// each byte is held in the input register, is decoded against the position and
// run state, and its result lands in the result register.
// Header and no-op bytes give no result, but a header whose run overruns the row
// gives an overrun result; a repeat run gives one result with a count. The cycle
// after reset and the cycle after any register write reload the row length and
// hold the decode step; keep config writes to idle periods.
module planar_byterun1_decoder (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [7:0]                         body_byte,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [7:0]                         value,
	output logic [7:0]                         repeat_res,
	output logic [pbrd_pkg::PLANE_W-1:0]       plane_index,
	output logic [pbrd_pkg::ROW_W-1:0]         row_index,
	output logic [pbrd_pkg::COL_W-1:0]         column,
	output logic                               row_end,
	output logic                               image_end,
	output logic                               overrun_error,
	input  logic                               cfg_we,
	input  logic [pbrd_pkg::CIDX_W-1:0]        cfg_index,
	input  logic [pbrd_pkg::CFG_W-1:0]         cfg_data
);
	import pbrd_pkg::*;

	cfg_t       cfg;
	logic       restart;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_valid_q;
	res_t       res, res_q;
	logic       res_vld;
	logic       adv;
	logic       ready_q;

	pbrd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.restart   (restart)
	);

	// step holds until the row length is loaded after reset or restart
	assign adv      = valid_s1 && ready_q && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	pbrd_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.restart (restart),
		.step_en (adv),
		.byte_s1 (byte_s1),
		.res     (res),
		.res_vld (res_vld)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0;
		end else begin
			ready_q <= !restart;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			byte_s1 <= body_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (adv && res_vld) || (out_valid_q && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_vld)
			res_q <= res;
	end

	assign out_valid     = out_valid_q;
	assign value         = res_q.value;
	assign repeat_res    = res_q.repeat_res;
	assign plane_index   = res_q.plane_index;
	assign row_index     = res_q.row_index;
	assign column        = res_q.column;
	assign row_end       = res_q.row_end;
	assign image_end     = res_q.image_end;
	assign overrun_error = res_q.overrun_error;

`ifndef NO_ASSERTIONS
	a_ovr_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.overrun_error |->
			res_q.repeat_res == 8'd0 && !res_q.row_end && !res_q.image_end)
		else $error("overrun beat carries data");

	a_count_nz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_q.overrun_error |-> res_q.repeat_res != 8'd0)
		else $error("data beat with zero count");

	a_img_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.image_end |-> res_q.row_end)
		else $error("image end without row end");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && (!ready_q || (out_valid_q && !out_ready)))
		else $error("input stalled without cause");
`endif

endmodule
